// ===== sv/sbae_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbae_pkg
// shared word types, instruction kinds and state codes for the byte alu
// execute unit
// ----------------------------------------------------------------------------
package sbae_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned AddrW = 16;
  localparam int unsigned RegIdxW = 2;
  localparam logic [DataW-1:0] SatMax = 8'hFF;

  // instruction kinds
  typedef enum logic [4:0] {
    K_MOVIMM   = 5'd0,
    K_STORE    = 5'd1,
    K_LOAD     = 5'd2,
    K_ADDR     = 5'd3,
    K_ADDI     = 5'd4,
    K_SUBR     = 5'd5,
    K_SUBI     = 5'd6,
    K_MULR     = 5'd7,
    K_MULI     = 5'd8,
    K_DIVR     = 5'd9,
    K_DIVI     = 5'd10,
    K_OUT      = 5'd11,
    K_STOREIMM = 5'd12,
    K_CLRREG   = 5'd13,
    K_CLRMEM   = 5'd14,
    K_CMP      = 5'd15,
    K_JMP      = 5'd16,
    K_JZ       = 5'd17,
    K_JCOND    = 5'd18
  } kind_t;

  // flag codes
  localparam logic [1:0] FlagNone  = 2'd0;
  localparam logic [1:0] FlagEqual = 2'd1;
  localparam logic [1:0] FlagOver  = 2'd2;
  localparam logic [1:0] FlagLess  = 2'd3;

  // jump conditions
  localparam logic [1:0] CondZero    = 2'd0;
  localparam logic [1:0] CondGreater = 2'd1;
  localparam logic [1:0] CondLess    = 2'd2;

  typedef struct packed {
    logic [4:0]       kind;
    logic [7:0]       first_reg;
    logic [7:0]       second_reg;
    logic [DataW-1:0] immediate;
    logic [AddrW-1:0] address;
    logic [1:0]       jump_cond;
  } in_word_t;

  typedef struct packed {
    logic [DataW-1:0] out_value;
    logic [1:0]       flags_now;
    logic             jump_taken;
    logic [AddrW-1:0] jump_target;
    logic             bad_register;
  } out_word_t;

  // divider handshake toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

endpackage

// ===== sv/sbae_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbae_div
// restoring byte divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sbae_div
  import sbae_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DataW-1:0] dividend,
  input  logic [DataW-1:0] divisor,
  output div_status_t      status,
  output logic [DataW-1:0] quotient
);

  logic [DataW-1:0] rem_r, rem_nxt;
  logic [DataW-1:0] quot_r, quot_nxt;
  logic [DataW-1:0] dvs_r;
  logic [2:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DataW:0]   trial;
  logic [DataW:0]   diff;
  logic             ge;

  // a zero divisor always subtracts, giving an all-ones quotient
  assign trial = {rem_r, quot_r[DataW-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quot_nxt = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[DataW-1:0] : trial[DataW-1:0];
      quot_nxt = {quot_r[DataW-2:0], ge};
      cnt_nxt  = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = quot_r;

endmodule

// ===== sv/saturating_byte_alu_execute_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saturating_byte_alu_execute_unit
// execute stage of a small 8-bit machine: four byte registers, a flags
// register and a byte data memory, one decoded instruction at a time
// ----------------------------------------------------------------------------
// order: for most kinds an instruction passes register and memory read, execute
//   and the result register before out_valid rises; divides also wait in S_DIV
//   on the one-bit-per-cycle divider loop
// flow: one instruction at a time, in_stall holds new words until DONE is left; the
//   next word is taken while the previous result still waits on out_stall
// reset: registers and flags clear to zero, data memory keeps its contents
// ----------------------------------------------------------------------------
module saturating_byte_alu_execute_unit
  import sbae_pkg::*;
#(
  parameter int unsigned MEM_ADDR_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int unsigned MemDepth = 1 << MEM_ADDR_BITS;

  // sequencer
  state_t state_r, state_nxt;

  // accepted instruction, held while it executes
  in_word_t ins_r;

  // register file: a small two-read one-write memory, valid bits give the
  // zero reset value
  logic [DataW-1:0] rf_mem [4];
  logic [3:0]       rf_vld_r;
  logic [DataW-1:0] rd_a_r, rd_b_r;
  logic             rf_we;
  logic [RegIdxW-1:0] rf_widx;
  logic [DataW-1:0] rf_wdata;

  // data memory, never reset
  logic [DataW-1:0] data_mem [MemDepth];
  logic [DataW-1:0] mem_q_r;
  logic             mem_we;
  logic [DataW-1:0] mem_wdata;

  logic [1:0] flags_r, flags_nxt;

  // finished result waiting for the output register
  out_word_t res_r, res_nxt;
  out_word_t out_word_r;
  logic      out_valid_r, out_valid_nxt;

  // decode of the held instruction
  logic [RegIdxW-1:0] idx1, idx2;
  logic [RegIdxW-1:0] in_idx1, in_idx2;
  logic ok1, ok2, need1, need2, bad;
  logic rr_form;
  logic [DataW-1:0] op_x, op_y;
  logic [DataW:0]   sum9, diff9;
  logic [2*DataW-1:0] prod;
  logic div_start;
  div_status_t div_st;
  logic [DataW-1:0] div_q;
  logic accept, out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // register numbers 1..4 map to entries 0..3
  assign in_idx1 = in_word.first_reg[RegIdxW-1:0] - 2'd1;
  assign in_idx2 = in_word.second_reg[RegIdxW-1:0] - 2'd1;
  assign idx1    = ins_r.first_reg[RegIdxW-1:0] - 2'd1;
  assign idx2    = ins_r.second_reg[RegIdxW-1:0] - 2'd1;
  assign ok1     = (ins_r.first_reg >= 8'd1) && (ins_r.first_reg <= 8'd4);
  assign ok2     = (ins_r.second_reg >= 8'd1) && (ins_r.second_reg <= 8'd4);

  always_comb begin
    need1   = 1'b0;
    need2   = 1'b0;
    rr_form = 1'b0;
    case (ins_r.kind) inside
      K_STORE, K_OUT, K_CLRREG: need1 = 1'b1;
      K_MOVIMM, K_LOAD, K_ADDI, K_SUBI, K_MULI, K_DIVI: need2 = 1'b1;
      K_ADDR, K_SUBR, K_MULR, K_DIVR, K_CMP: begin
        need1   = 1'b1;
        need2   = 1'b1;
        rr_form = 1'b1;
      end
      default: ;
    endcase
  end

  assign bad = (need1 && !ok1) || (need2 && !ok2);

  // register-register forms take A op B, immediate forms B op imm
  assign op_x  = rr_form ? rd_a_r : rd_b_r;
  assign op_y  = rr_form ? rd_b_r : ins_r.immediate;
  assign sum9  = {1'b0, op_x} + {1'b0, op_y};
  assign diff9 = {1'b0, op_x} - {1'b0, op_y};
  assign prod  = op_x * op_y;

  sbae_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (op_x),
    .divisor  (op_y),
    .status   (div_st),
    .quotient (div_q)
  );

  // execute and sequence
  always_comb begin
    state_nxt = state_r;
    flags_nxt = flags_r;
    res_nxt   = res_r;
    rf_we     = 1'b0;
    rf_widx   = idx2;
    rf_wdata  = '0;
    mem_we    = 1'b0;
    mem_wdata = '0;
    div_start = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        res_nxt              = '0;
        res_nxt.bad_register = bad;
        state_nxt            = S_DONE;
        if (!bad) begin
          case (ins_r.kind) inside
            K_MOVIMM: begin
              rf_we    = 1'b1;
              rf_wdata = ins_r.immediate;
            end
            K_STORE: begin
              mem_we    = 1'b1;
              mem_wdata = rd_a_r;
            end
            K_LOAD: begin
              rf_we    = 1'b1;
              rf_wdata = mem_q_r;
            end
            K_ADDR, K_ADDI: begin
              rf_we     = 1'b1;
              rf_wdata  = sum9[DataW] ? SatMax : sum9[DataW-1:0];
              flags_nxt = sum9[DataW] ? FlagOver : FlagNone;
            end
            K_SUBR, K_SUBI: begin
              // borrow means underflow, clamp to zero
              rf_we     = 1'b1;
              rf_wdata  = diff9[DataW] ? '0 : diff9[DataW-1:0];
              flags_nxt = diff9[DataW] ? FlagLess : FlagNone;
            end
            K_MULR, K_MULI: begin
              rf_we     = 1'b1;
              rf_wdata  = (prod[2*DataW-1:DataW] != '0) ? SatMax : prod[DataW-1:0];
              flags_nxt = (prod[2*DataW-1:DataW] != '0) ? FlagOver : FlagNone;
            end
            K_DIVR, K_DIVI: begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
            K_OUT: begin
              res_nxt.out_value = rd_a_r;
            end
            K_STOREIMM: begin
              mem_we    = 1'b1;
              mem_wdata = ins_r.immediate;
            end
            K_CLRREG: begin
              rf_we   = 1'b1;
              rf_widx = idx1;
            end
            K_CLRMEM: begin
              mem_we = 1'b1;
            end
            K_CMP: begin
              if (rd_a_r == rd_b_r) begin
                flags_nxt = FlagEqual;
              end else if (rd_a_r > rd_b_r) begin
                flags_nxt = FlagOver;
              end else begin
                flags_nxt = FlagLess;
              end
            end
            K_JMP: begin
              res_nxt.jump_taken = 1'b1;
            end
            K_JZ: begin
              res_nxt.jump_taken = (flags_r == FlagEqual);
            end
            K_JCOND: begin
              case (ins_r.jump_cond)
                CondZero:    res_nxt.jump_taken = (flags_r == FlagEqual);
                CondGreater: res_nxt.jump_taken = (flags_r == FlagOver);
                CondLess:    res_nxt.jump_taken = (flags_r == FlagLess);
                default:     res_nxt.jump_taken = 1'b0;
              endcase
            end
            default: ;
          endcase
        end
        res_nxt.flags_now   = flags_nxt;
        res_nxt.jump_target = res_nxt.jump_taken ? ins_r.address : '0;
      end

      S_DIV: begin
        // divide leaves the flags alone
        if (div_st.done) begin
          rf_we     = 1'b1;
          rf_wdata  = div_q;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == S_DONE) && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      flags_r     <= FlagNone;
      out_valid_r <= 1'b0;
      rf_vld_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      flags_r     <= flags_nxt;
      out_valid_r <= out_valid_nxt;
      if (rf_we) begin
        rf_vld_r[rf_widx] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ins_r <= in_word;
    end
    res_r <= res_nxt;
    if ((state_r == S_DONE) && out_free) begin
      out_word_r <= res_r;
    end
  end

  // register file ports: reads at accept, the write happens in a later
  // cycle of the same instruction, so the two never meet
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[rf_widx] <= rf_wdata;
    end
    if (accept) begin
      rd_a_r <= rf_vld_r[in_idx1] ? rf_mem[in_idx1] : '0;
      rd_b_r <= rf_vld_r[in_idx2] ? rf_mem[in_idx2] : '0;
    end
  end

  // data memory: read at accept, written during execute
  always_ff @(posedge clk) begin
    if (mem_we) begin
      data_mem[ins_r.address[MEM_ADDR_BITS-1:0]] <= mem_wdata;
    end
    if (accept) begin
      mem_q_r <= data_mem[in_word.address[MEM_ADDR_BITS-1:0]];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== sv/sbae_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbae_checker
// port-level checks for the byte alu execute unit
// ----------------------------------------------------------------------------
module sbae_checker
  import sbae_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  // one instruction in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("word accepted while previous one executes");

  // no target without a taken jump
  a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.jump_taken |-> out_word.jump_target == '0)
    else $error("jump target set without taken jump");

  // a bad register number has no effect in the result
  a_bad_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.bad_register |->
      out_word.out_value == '0 && !out_word.jump_taken)
    else $error("bad register word shows a value or a jump");

endmodule

bind saturating_byte_alu_execute_unit sbae_checker u_sbae_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
